// ===== rtl/core/scfr_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants and types for the serial command frame receiver.
// Used by every module in rtl/core; depends on nothing else.
package scfr_pkg;

    localparam int STORE_DEPTH = 64;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int SIZE_W      = 6;
    localparam int OFFSET_W    = 7;

    localparam logic [7:0] HDR_A       = 8'h24;
    localparam logic [7:0] HDR_B       = 8'h4D;
    localparam logic [7:0] HDR_C       = 8'h3E;
    localparam logic [7:0] CMD_FLOOR   = 8'd99;
    localparam logic [7:0] SIZE_LIMIT  = 8'd100;
    localparam logic [7:0] MAX_PAYLOAD = 8'd63;

    localparam logic [7:0] PH_IDLE  = 8'd0;
    localparam logic [7:0] PH_HDR1  = 8'd1;
    localparam logic [7:0] PH_HDR2  = 8'd2;
    localparam logic [7:0] PH_HDR3  = 8'd3;
    localparam logic [7:0] PH_SIZE  = 8'd4;
    localparam logic [7:0] PH_LIMIT = 8'd5;

    localparam logic [15:0] TALLY_MAX = 16'hFFFF;

    typedef struct packed {
        logic              valid;
        logic [7:0]        cmd;
        logic [SIZE_W-1:0] size;
        logic [7:0]        xor_sum;
    } judge_req_t;

endpackage

// ===== rtl/core/scfr_store.sv =====
`timescale 1ns / 1ps
// Payload byte store: one write port and one registered read port.
// Depends on scfr_pkg for its depth and address width.
module scfr_store
    import scfr_pkg::*;
(
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [7:0]        wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [7:0]        rd_data
);

    logic [7:0] mem [STORE_DEPTH];
    logic [7:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/core/scfr_parse.sv =====
`timescale 1ns / 1ps
// Byte-level frame parser: header hunt, size and command capture, payload writes.
// Depends on scfr_pkg; feeds scfr_store and hands judged frames to scfr_readout.
module scfr_parse
    import scfr_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  logic [7:0]        rx_byte,
    output logic              wr_en,
    output logic [ADDR_W-1:0] wr_addr,
    output logic [7:0]        wr_data,
    output judge_req_t        judge
);

    logic [7:0]          phase_reg, phase_next;
    logic [SIZE_W-1:0]   size_reg, size_next;
    logic [OFFSET_W-1:0] offset_reg, offset_next;
    logic [7:0]          xor_reg, xor_next;
    logic                store_hit;
    logic                judge_hit;

    always_comb
    begin
        phase_next  = phase_reg;
        size_next   = size_reg;
        offset_next = offset_reg;
        xor_next    = xor_reg;
        store_hit   = 1'b0;
        judge_hit   = 1'b0;

        if (phase_next > CMD_FLOOR)
        begin
            if (offset_next <= {1'b0, size_next})
            begin
                store_hit = 1'b1;
                if (offset_next < {1'b0, size_next})
                begin
                    xor_next = xor_next ^ rx_byte;
                end
                offset_next = offset_next + OFFSET_W'(1);
            end
            else
            begin
                judge_hit  = 1'b1;
                phase_next = PH_IDLE;
            end
        end

        if (phase_next < PH_LIMIT)
        begin
            if (phase_next == PH_SIZE)
            begin
                if (rx_byte > CMD_FLOOR)
                begin
                    phase_next  = rx_byte;
                    offset_next = '0;
                    xor_next    = '0;
                end
                else
                begin
                    phase_next = PH_IDLE;
                end
            end
            if (phase_next == PH_HDR3)
            begin
                if (rx_byte < SIZE_LIMIT)
                begin
                    phase_next = PH_SIZE;
                    size_next  = (rx_byte > MAX_PAYLOAD) ? MAX_PAYLOAD[SIZE_W-1:0]
                                                         : rx_byte[SIZE_W-1:0];
                end
                else
                begin
                    phase_next = rx_byte;
                end
            end
            if (rx_byte == HDR_A && phase_next == PH_IDLE)
            begin
                phase_next = PH_HDR1;
            end
            else if (rx_byte == HDR_B && phase_next == PH_HDR1)
            begin
                phase_next = PH_HDR2;
            end
            else if (rx_byte == HDR_C && phase_next == PH_HDR2)
            begin
                phase_next = PH_HDR3;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_IDLE;
            size_reg   <= '0;
            offset_reg <= '0;
            xor_reg    <= '0;
        end
        else if (accept)
        begin
            phase_reg  <= phase_next;
            size_reg   <= size_next;
            offset_reg <= offset_next;
            xor_reg    <= xor_next;
        end
    end

    assign wr_en   = accept & store_hit;
    assign wr_addr = offset_reg[ADDR_W-1:0];
    assign wr_data = rx_byte;

    assign judge.valid   = accept & judge_hit;
    assign judge.cmd     = phase_reg;
    assign judge.size    = size_reg;
    assign judge.xor_sum = xor_reg;

endmodule

// ===== rtl/core/scfr_readout.sv =====
`timescale 1ns / 1ps
// Frame judgment and result sequencer: checksum compare, error tally, payload readout.
// Depends on scfr_pkg; drives the read port of scfr_store and the output beat register.
module scfr_readout
    import scfr_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  judge_req_t        judge,
    output logic              busy,
    output logic              rd_en,
    output logic [ADDR_W-1:0] rd_addr,
    input  logic [7:0]        rd_data,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [7:0]        command_code,
    output logic [5:0]        payload_length,
    output logic              has_byte,
    output logic [7:0]        payload_data,
    output logic [5:0]        byte_position,
    output logic              frame_good,
    output logic [15:0]       bad_frame_count,
    output logic              last
);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_CHECK  = 4'b0010,
        S_FETCH  = 4'b0100,
        S_STATUS = 4'b1000
    } rd_state_t;

    rd_state_t         state_reg, state_next;
    logic [7:0]        cmd_reg, cmd_next;
    logic [SIZE_W-1:0] size_reg, size_next;
    logic [7:0]        xor_reg, xor_next;
    logic [SIZE_W-1:0] idx_reg, idx_next;
    logic              good_reg, good_next;
    logic [15:0]       tally_reg, tally_next;

    logic              out_valid_reg, out_valid_next;
    logic              has_reg, has_next;
    logic [7:0]        data_reg, data_next;
    logic [SIZE_W-1:0] pos_reg, pos_next;
    logic              ogood_reg, ogood_next;
    logic [15:0]       count_reg, count_next;
    logic              last_reg, last_next;
    logic [7:0]        ocmd_reg, ocmd_next;
    logic [SIZE_W-1:0] olen_reg, olen_next;

    logic              slot_free;
    logic              load;

    assign slot_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next = state_reg;
        cmd_next   = cmd_reg;
        size_next  = size_reg;
        xor_next   = xor_reg;
        idx_next   = idx_reg;
        good_next  = good_reg;
        tally_next = tally_reg;
        rd_en      = 1'b0;
        rd_addr    = '0;
        load       = 1'b0;
        has_next   = has_reg;
        data_next  = data_reg;
        pos_next   = pos_reg;
        ogood_next = ogood_reg;
        count_next = count_reg;
        last_next  = last_reg;
        ocmd_next  = ocmd_reg;
        olen_next  = olen_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (judge.valid)
                begin
                    cmd_next   = judge.cmd;
                    size_next  = judge.size;
                    xor_next   = judge.xor_sum;
                    rd_en      = 1'b1;
                    rd_addr    = judge.size;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (rd_data == xor_reg)
                begin
                    good_next = 1'b1;
                    if (size_reg == '0)
                    begin
                        state_next = S_STATUS;
                    end
                    else
                    begin
                        rd_en      = 1'b1;
                        rd_addr    = '0;
                        idx_next   = '0;
                        state_next = S_FETCH;
                    end
                end
                else
                begin
                    good_next = 1'b0;
                    if (tally_reg != TALLY_MAX)
                    begin
                        tally_next = tally_reg + 16'd1;
                    end
                    state_next = S_STATUS;
                end
            end
            S_FETCH:
            begin
                if (slot_free)
                begin
                    load       = 1'b1;
                    has_next   = 1'b1;
                    data_next  = rd_data;
                    pos_next   = idx_reg;
                    ogood_next = 1'b1;
                    count_next = tally_reg;
                    last_next  = 1'b0;
                    ocmd_next  = cmd_reg;
                    olen_next  = size_reg;
                    if (idx_reg + SIZE_W'(1) < size_reg)
                    begin
                        rd_en    = 1'b1;
                        rd_addr  = idx_reg + SIZE_W'(1);
                        idx_next = idx_reg + SIZE_W'(1);
                    end
                    else
                    begin
                        state_next = S_STATUS;
                    end
                end
            end
            S_STATUS:
            begin
                if (slot_free)
                begin
                    load       = 1'b1;
                    has_next   = 1'b0;
                    data_next  = '0;
                    pos_next   = '0;
                    ogood_next = good_reg;
                    count_next = tally_reg;
                    last_next  = 1'b1;
                    ocmd_next  = cmd_reg;
                    olen_next  = size_reg;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            tally_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            tally_reg     <= tally_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg   <= cmd_next;
        size_reg  <= size_next;
        xor_reg   <= xor_next;
        idx_reg   <= idx_next;
        good_reg  <= good_next;
        has_reg   <= has_next;
        data_reg  <= data_next;
        pos_reg   <= pos_next;
        ogood_reg <= ogood_next;
        count_reg <= count_next;
        last_reg  <= last_next;
        ocmd_reg  <= ocmd_next;
        olen_reg  <= olen_next;
    end

    assign busy            = (state_reg != S_IDLE);
    assign out_valid       = out_valid_reg;
    assign command_code    = ocmd_reg;
    assign payload_length  = olen_reg;
    assign has_byte        = has_reg;
    assign payload_data    = data_reg;
    assign byte_position   = pos_reg;
    assign frame_good      = ogood_reg;
    assign bad_frame_count = count_reg;
    assign last            = last_reg;

endmodule

// ===== rtl/core/serial_command_frame_receiver.sv =====
`timescale 1ns / 1ps
// Top level of the serial command frame receiver.
// Depends on scfr_pkg, scfr_store, scfr_parse and scfr_readout.

// Received bytes are taken one per cycle while no frame is being judged. The byte
// after a frame's checksum byte judges the frame: the checksum byte is read back
// from the 64-byte payload store, and input then stays stalled while a good frame
// sends its payload beats, one per cycle from the store's read port while the
// output is not stalled, and the closing status beat. A bad frame sends one status
// beat and bumps the saturating error count. The output beat sits in a register,
// so bytes keep being taken while a status beat waits.
module serial_command_frame_receiver
    import scfr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  rx_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  command_code,
    output logic [5:0]  payload_length,
    output logic        has_byte,
    output logic [7:0]  payload_data,
    output logic [5:0]  byte_position,
    output logic        frame_good,
    output logic [15:0] bad_frame_count,
    output logic        last
);

    logic              busy;
    logic              accept;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [7:0]        wr_data;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic [7:0]        rd_data;
    judge_req_t        judge;

    assign in_stall = busy;
    assign accept   = in_valid && !busy;

    scfr_store u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    scfr_parse u_parse (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .rx_byte (rx_byte),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .judge   (judge)
    );

    scfr_readout u_readout (
        .clk             (clk),
        .rst_n           (rst_n),
        .judge           (judge),
        .busy            (busy),
        .rd_en           (rd_en),
        .rd_addr         (rd_addr),
        .rd_data         (rd_data),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .command_code    (command_code),
        .payload_length  (payload_length),
        .has_byte        (has_byte),
        .payload_data    (payload_data),
        .byte_position   (byte_position),
        .frame_good      (frame_good),
        .bad_frame_count (bad_frame_count),
        .last            (last)
    );

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for serial_command_frame_receiver: directed and random serial
// byte streams, a frame parser model that predicts every output beat, and a scoreboard.
// Depends on scfr_pkg and the serial_command_frame_receiver RTL.
module tb_top;
    import scfr_pkg::*;

    localparam int IDLE_PCT     = 21;
    localparam int RANDOM_BYTES = 110;
    localparam int DRAIN_CYCLES = 80;
    localparam int QUIET_LIMIT  = 2000;
    localparam int DIRECTED_N   = 25;
    localparam logic [7:0] SAT_CMD  = 8'd200;
    localparam logic [7:0] FILL_CMD = 8'd150;

    typedef struct packed {
        logic [7:0]  rx;
        logic        typed;
        logic [7:0]  want_cmd;
        logic [5:0]  want_len;
        logic        want_good;
        logic [15:0] want_tally;
    } stim_row_t;

    typedef struct packed {
        logic [7:0]  cmd;
        logic [5:0]  len;
        logic        has;
        logic [7:0]  data;
        logic [5:0]  pos;
        logic        good;
        logic [15:0] tally;
        logic        lst;
    } frame_beat_t;

    logic        clk;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic        in_stall;
    logic [7:0]  rx_byte   = 8'h00;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [7:0]  command_code;
    logic [5:0]  payload_length;
    logic        has_byte;
    logic [7:0]  payload_data;
    logic [5:0]  byte_position;
    logic        frame_good;
    logic [15:0] bad_frame_count;
    logic        last;

    stim_row_t   directed_rows [DIRECTED_N];
    stim_row_t   rx_stream [$];
    frame_beat_t frame_beats_due [$];
    int          mismatch_count = 0;
    int          quiet_cycles   = 0;
    int          calm_from;
    int          calm_to;
    logic        calm = 1'b0;

    // Parser model state.
    logic [7:0]  ph;
    logic [5:0]  fsize;
    logic [6:0]  woff;
    logic [7:0]  xsum;
    logic [7:0]  pstore [STORE_DEPTH];
    logic [15:0] bad_tally;

    serial_command_frame_receiver dut (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic void add_byte(input logic [7:0] v);
        rx_stream.push_back('{v, 1'b0, 8'd0, 6'd0, 1'b0, 16'd0});
    endfunction

    function automatic void add_header();
        add_byte(HDR_A);
        add_byte(HDR_B);
        add_byte(HDR_C);
    endfunction

    // A full-size good frame writes every store entry, so later frames that reuse
    // a stale size and offset only read back bytes that were stored before.
    function automatic void add_fill_frame();
        logic [7:0] x;
        logic [7:0] b;
        x = 8'h00;
        add_header();
        add_byte(MAX_PAYLOAD);
        add_byte(FILL_CMD);
        repeat (MAX_PAYLOAD)
        begin
            b = 8'($urandom);
            x = x ^ b;
            add_byte(b);
        end
        add_byte(x);
    endfunction

    function automatic void add_random_traffic();
        int kind;
        int pick;
        int sz;
        int n;
        int first;
        int made;
        logic [7:0] x;
        logic [7:0] b;
        made = 0;
        while (made < RANDOM_BYTES)
        begin
            first = rx_stream.size();
            kind  = $urandom_range(0, 99);
            if (kind < 60)
            begin
                add_header();
                pick = $urandom_range(0, 99);
                if (pick < 85)
                    sz = $urandom_range(0, 8);
                else if (pick < 96)
                    sz = $urandom_range(9, 63);
                else
                    sz = $urandom_range(64, 99);
                add_byte(8'(sz));
                add_byte(8'($urandom_range(100, 255)));
                n = (sz > 63) ? 63 : sz;
                x = 8'h00;
                repeat (n)
                begin
                    b = 8'($urandom);
                    x = x ^ b;
                    add_byte(b);
                end
                if ($urandom_range(0, 4) == 0)
                    x = x ^ 8'($urandom_range(1, 255));
                add_byte(x);
            end
            else if (kind < 70)
            begin
                add_header();
                add_byte(8'($urandom_range(100, 255)));
                repeat ($urandom_range(0, 4))
                    add_byte(8'($urandom));
            end
            else if (kind < 78)
            begin
                add_header();
                add_byte(8'($urandom_range(0, 99)));
                add_byte(8'($urandom_range(0, 99)));
            end
            else
            begin
                repeat ($urandom_range(1, 5))
                begin
                    case ($urandom_range(0, 4))
                        0: add_byte(HDR_A);
                        1: add_byte(HDR_B);
                        2: add_byte(HDR_C);
                        default: add_byte(8'($urandom));
                    endcase
                end
            end
            made += rx_stream.size() - first;
        end
    endfunction

    task automatic parse_rx_byte(input stim_row_t r);
        frame_beat_t b;
        logic [7:0]  c;
        logic [7:0]  clamped;
        int          i;
        c = r.rx;
        if (ph > CMD_FLOOR)
        begin
            if (woff <= {1'b0, fsize})
            begin
                if (woff < {1'b0, fsize})
                    xsum = xsum ^ c;
                pstore[woff[5:0]] = c;
                woff = woff + 7'd1;
            end
            else
            begin
                b.cmd  = ph;
                b.len  = fsize;
                b.lst  = 1'b0;
                b.has  = 1'b1;
                b.good = 1'b1;
                if (xsum == pstore[fsize])
                begin
                    b.tally = bad_tally;
                    for (i = 0; i < fsize; i++)
                    begin
                        b.data = pstore[i];
                        b.pos  = 6'(i);
                        frame_beats_due.push_back(b);
                    end
                end
                else
                begin
                    if (bad_tally != TALLY_MAX)
                        bad_tally = bad_tally + 16'd1;
                    b.good = 1'b0;
                end
                b.has   = 1'b0;
                b.data  = 8'h00;
                b.pos   = 6'd0;
                b.tally = bad_tally;
                b.lst   = 1'b1;
                if (r.typed)
                begin
                    b.cmd   = r.want_cmd;
                    b.len   = r.want_len;
                    b.good  = r.want_good;
                    b.tally = r.want_tally;
                end
                frame_beats_due.push_back(b);
                ph = PH_IDLE;
            end
        end
        if (ph < PH_LIMIT)
        begin
            if (ph == PH_SIZE)
            begin
                if (c > CMD_FLOOR)
                begin
                    ph   = c;
                    woff = 7'd0;
                    xsum = 8'h00;
                end
                else
                    ph = PH_IDLE;
            end
            if (ph == PH_HDR3)
            begin
                if (c < SIZE_LIMIT)
                begin
                    ph      = PH_SIZE;
                    clamped = (c > MAX_PAYLOAD) ? MAX_PAYLOAD : c;
                    fsize   = clamped[5:0];
                end
                else
                    ph = c;
            end
            if (c == HDR_A && ph == PH_IDLE)
                ph = PH_HDR1;
            else if (c == HDR_B && ph == PH_HDR1)
                ph = PH_HDR2;
            else if (c == HDR_C && ph == PH_HDR2)
                ph = PH_HDR3;
        end
    endtask

    function automatic void check_field(input string field, input logic [15:0] want,
                                        input logic [15:0] got);
        if (got !== want)
        begin
            mismatch_count++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
        end
    endfunction

    always @(posedge clk)
    begin
        frame_beat_t w;
        if (rst_n && out_valid && !out_stall)
        begin
            if (frame_beats_due.size() == 0)
            begin
                mismatch_count++;
                $display("%0t: unexpected beat, expected none, actual cmd %0h data %0h",
                         $time, command_code, payload_data);
            end
            else
            begin
                w = frame_beats_due.pop_front();
                check_field("command_code", 16'(w.cmd), 16'(command_code));
                check_field("payload_length", 16'(w.len), 16'(payload_length));
                check_field("has_byte", 16'(w.has), 16'(has_byte));
                check_field("payload_data", 16'(w.data), 16'(payload_data));
                check_field("byte_position", 16'(w.pos), 16'(byte_position));
                check_field("frame_good", 16'(w.good), 16'(frame_good));
                check_field("bad_frame_count", w.tally, bad_frame_count);
                check_field("last", 16'(w.lst), 16'(last));
            end
        end
    end

    always @(posedge clk)
    begin
        out_stall <= !calm && ($urandom_range(0, 99) < IDLE_PCT);
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        while (quiet_cycles < QUIET_LIMIT)
            @(posedge clk);
        $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        int idx;
        int i;
        // Oversize size byte, then a bad command byte that restarts the header.
        directed_rows[0]  = '{HDR_A, 1'b0, 8'd0, 6'd0, 1'b0, 16'd0};
        directed_rows[1]  = '{HDR_B, 1'b0, 8'd0, 6'd0, 1'b0, 16'd0};
        directed_rows[2]  = '{HDR_C, 1'b0, 8'd0, 6'd0, 1'b0, 16'd0};
        directed_rows[3]  = '{8'd99, 1'b0, 8'd0, 6'd0, 1'b0, 16'd0};
        directed_rows[4]  = '{HDR_A, 1'b0, 8'd0, 6'd0, 1'b0, 16'd0};
        // Header mismatches in both partial header phases, then a good frame.
        directed_rows[5]  = '{8'h55, 1'b0, 8'd0, 6'd0, 1'b0, 16'd0};
        directed_rows[6]  = '{HDR_B, 1'b0, 8'd0, 6'd0, 1'b0, 16'd0};
        directed_rows[7]  = '{8'h00, 1'b0, 8'd0, 6'd0, 1'b0, 16'd0};
        directed_rows[8]  = '{HDR_C, 1'b0, 8'd0, 6'd0, 1'b0, 16'd0};
        directed_rows[9]  = '{8'd2,  1'b0, 8'd0, 6'd0, 1'b0, 16'd0};
        directed_rows[10] = '{8'hFF, 1'b0, 8'd0, 6'd0, 1'b0, 16'd0};
        directed_rows[11] = '{8'hFF, 1'b0, 8'd0, 6'd0, 1'b0, 16'd0};
        directed_rows[12] = '{8'h00, 1'b0, 8'd0, 6'd0, 1'b0, 16'd0};
        directed_rows[13] = '{8'hFF, 1'b0, 8'd0, 6'd0, 1'b0, 16'd0};
        directed_rows[14] = '{HDR_A, 1'b1, 8'd255, 6'd2, 1'b1, 16'd0};
        // Empty frame with the lowest command and a wrong checksum.
        directed_rows[15] = '{HDR_B, 1'b0, 8'd0, 6'd0, 1'b0, 16'd0};
        directed_rows[16] = '{HDR_C, 1'b0, 8'd0, 6'd0, 1'b0, 16'd0};
        directed_rows[17] = '{8'd0,  1'b0, 8'd0, 6'd0, 1'b0, 16'd0};
        directed_rows[18] = '{SIZE_LIMIT, 1'b0, 8'd0, 6'd0, 1'b0, 16'd0};
        directed_rows[19] = '{8'h01, 1'b0, 8'd0, 6'd0, 1'b0, 16'd0};
        directed_rows[20] = '{HDR_A, 1'b1, 8'd100, 6'd0, 1'b0, 16'd1};
        // Command in the size slot with a stale offset already past the size.
        directed_rows[21] = '{HDR_B, 1'b0, 8'd0, 6'd0, 1'b0, 16'd0};
        directed_rows[22] = '{HDR_C, 1'b0, 8'd0, 6'd0, 1'b0, 16'd0};
        directed_rows[23] = '{SAT_CMD, 1'b0, 8'd0, 6'd0, 1'b0, 16'd0};
        directed_rows[24] = '{8'h00, 1'b1, SAT_CMD, 6'd0, 1'b0, 16'd2};
        for (i = 0; i < DIRECTED_N; i++)
            rx_stream.push_back(directed_rows[i]);
        add_fill_frame();
        add_random_traffic();
        calm_from = rx_stream.size();
        add_random_traffic();
        calm_to = rx_stream.size();

        ph        = PH_IDLE;
        fsize     = 6'd0;
        woff      = 7'd0;
        xsum      = 8'h00;
        bad_tally = 16'd0;
        for (i = 0; i < STORE_DEPTH; i++)
            pstore[i] = 8'h00;

        repeat (9)
            @(posedge clk);
        rst_n <= 1'b1;

        idx = 0;
        while (idx < rx_stream.size())
        begin
            @(posedge clk);
            if (in_valid && !in_stall)
            begin
                parse_rx_byte(rx_stream[idx]);
                idx++;
            end
            calm = (idx >= calm_from) && (idx < calm_to);
            if (in_valid && in_stall)
                in_valid <= 1'b1;
            else if (idx < rx_stream.size() && (calm || $urandom_range(0, 99) >= IDLE_PCT))
            begin
                in_valid <= 1'b1;
                rx_byte  <= rx_stream[idx].rx;
            end
            else
                in_valid <= 1'b0;
        end

        while (frame_beats_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);
        if (mismatch_count == 0 && frame_beats_due.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/scfr_pkg.sv
rtl/core/scfr_store.sv
rtl/core/scfr_parse.sv
rtl/core/scfr_readout.sv
rtl/core/serial_command_frame_receiver.sv
sim/tb_top.sv
